### hw/rtl/rbsi_pkg.sv
// ----------------------------------------------------------------------------
// rbsi_pkg
// Types and constants shared by the ray versus cube slab test pipeline.
// ----------------------------------------------------------------------------
package rbsi_pkg;

   // lane and stage counts
   localparam int AXES       = 3;
   localparam int LANES      = 2 * AXES;
   localparam int NUM_W      = 32;
   localparam int DIV_STAGES = 48;
   localparam int SQ_W       = DIV_STAGES + 1;
   localparam int PROD_W     = 63;

   // configuration register indexes
   localparam int CSR_IDX_W = 2;
   localparam logic [CSR_IDX_W-1:0] CSR_HALF_SIDE = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_FACE_TOL  = 2'd1;

   localparam logic [30:0] HALF_SIDE_RST = 31'h0000_8000;
   localparam logic [15:0] FACE_TOL_RST  = 16'd16;

   // distance limits
   localparam logic [30:0]     T_SAT     = 31'h7FFF_FFFF;
   localparam logic [SQ_W-1:0] T_NEG_INF = {1'b1, {(SQ_W-1){1'b0}}};
   localparam logic [SQ_W-1:0] T_POS_INF = {1'b0, {(SQ_W-1){1'b1}}};

   // face codes
   localparam logic [2:0] FACE_PX   = 3'd0;
   localparam logic [2:0] FACE_MX   = 3'd3;
   localparam logic [2:0] FACE_NONE = 3'd6;

   typedef struct packed {
      logic signed [31:0] origin_x;
      logic signed [31:0] origin_y;
      logic signed [31:0] origin_z;
      logic signed [31:0] dir_x;
      logic signed [31:0] dir_y;
      logic signed [31:0] dir_z;
   } rbsi_req_type;

   typedef struct packed {
      logic               hit;
      logic [30:0]        t_hit;
      logic signed [31:0] point_x;
      logic signed [31:0] point_y;
      logic signed [31:0] point_z;
      logic [2:0]         face;
   } rbsi_rsp_type;

   // per-ray data that rides alongside the dividers
   typedef struct packed {
      logic [AXES-1:0][31:0] org;
      logic [AXES-1:0][31:0] dmag;
      logic [AXES-1:0]       dneg;
      logic [AXES-1:0]       dzero;
      logic                  par_miss;
   } rbsi_side_type;

   // divider operands, lane 2*axis is the minus plane, 2*axis+1 the plus plane
   typedef struct packed {
      logic [LANES-1:0][NUM_W-1:0] num;
      logic [LANES-1:0][NUM_W-1:0] den;
      logic [LANES-1:0]            neg;
   } rbsi_div_op_type;

   typedef struct packed {
      rbsi_side_type                    side;
      logic [LANES-1:0][DIV_STAGES-1:0] quo;
      logic [LANES-1:0]                 neg;
   } rbsi_div_res_type;

endpackage

### hw/rtl/rbsi_front.sv
// ----------------------------------------------------------------------------
// rbsi_front
// Input stage: slab numerators, direction magnitudes and parallel-axis miss.
// ----------------------------------------------------------------------------
module rbsi_front (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     en,
   input  logic                     in_valid,
   input  rbsi_pkg::rbsi_req_type   in_req,
   input  logic [30:0]              half_side,
   output logic                     out_valid,
   output rbsi_pkg::rbsi_side_type  out_side,
   output rbsi_pkg::rbsi_div_op_type out_op
);

   logic                      valid_ff;
   rbsi_pkg::rbsi_side_type   side_ff, side_in;
   rbsi_pkg::rbsi_div_op_type op_ff, op_in;
   logic [rbsi_pkg::AXES-1:0][31:0] org, dir;

   assign org = {in_req.origin_z, in_req.origin_y, in_req.origin_x};
   assign dir = {in_req.dir_z, in_req.dir_y, in_req.dir_x};

   // per axis: (-h - o) and (h - o) as sign and magnitude
   always_comb begin
      logic signed [33:0] h34, o34, nl, nh;
      logic [33:0]        ml, mh;
      logic [rbsi_pkg::AXES-1:0] out_slab;
      side_in  = '0;
      op_in    = '0;
      out_slab = '0;
      for (int a = 0; a < rbsi_pkg::AXES; a++) begin
         h34 = $signed({3'b000, half_side});
         o34 = $signed({{2{org[a][31]}}, org[a]});
         nl  = -h34 - o34;
         nh  = h34 - o34;
         ml  = nl[33] ? 34'(-nl) : 34'(nl);
         mh  = nh[33] ? 34'(-nh) : 34'(nh);
         side_in.org[a]   = org[a];
         side_in.dneg[a]  = dir[a][31];
         side_in.dmag[a]  = dir[a][31] ? (32'd0 - dir[a]) : dir[a];
         side_in.dzero[a] = (dir[a] == 32'd0);
         out_slab[a]      = (nl > 34'sd0) || (nh < 34'sd0);
         op_in.num[2*a]   = ml[31:0];
         op_in.num[2*a+1] = mh[31:0];
         op_in.den[2*a]   = side_in.dmag[a];
         op_in.den[2*a+1] = side_in.dmag[a];
         op_in.neg[2*a]   = nl[33] ^ dir[a][31];
         op_in.neg[2*a+1] = nh[33] ^ dir[a][31];
      end
      side_in.par_miss = |(side_in.dzero & out_slab);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (en) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         side_ff <= side_in;
         op_ff   <= op_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_side  = side_ff;
   assign out_op    = op_ff;

endmodule

### hw/rtl/rbsi_div_pipe.sv
// ----------------------------------------------------------------------------
// rbsi_div_pipe
// Six-lane restoring divider, one quotient bit per stage, (num << 16) / den.
// ----------------------------------------------------------------------------
module rbsi_div_pipe (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       en,
   input  logic                       in_valid,
   input  rbsi_pkg::rbsi_side_type    in_side,
   input  rbsi_pkg::rbsi_div_op_type  in_op,
   output logic                       out_valid,
   output rbsi_pkg::rbsi_div_res_type out_res
);

   localparam int NS = rbsi_pkg::DIV_STAGES;
   localparam int NL = rbsi_pkg::LANES;
   localparam int NW = rbsi_pkg::NUM_W;

   typedef struct packed {
      rbsi_pkg::rbsi_side_type side;
      logic [NL-1:0][NW-1:0]   num;
      logic [NL-1:0][NW-1:0]   den;
      logic [NL-1:0]           neg;
      logic [NL-1:0][NW-1:0]   rem;
      logic [NL-1:0][NS-1:0]   quo;
   } div_stage_type;

   logic [NS-1:0] valid_ff;
   div_stage_type stage_ff [NS];
   div_stage_type stage_in [NS];

   // valid bits travel with the data
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (en) begin
         valid_ff <= {valid_ff[NS-2:0], in_valid};
      end
   end

   for (genvar k = 0; k < NS; k++) begin : g_stage
      // dividend bit entering at this stage, low 16 bits of the dividend are zero
      localparam bit BIT_USED = (k < NW);
      localparam int BIT_IDX  = (k < NW) ? (NW - 1 - k) : 0;

      div_stage_type src;

      if (k == 0) begin : g_first
         always_comb begin
            src      = '0;
            src.side = in_side;
            src.num  = in_op.num;
            src.den  = in_op.den;
            src.neg  = in_op.neg;
         end
      end else begin : g_next
         assign src = stage_ff[k-1];
      end

      // one trial subtract per lane
      always_comb begin
         logic [NW:0] trial;
         logic [NW:0] diff;
         stage_in[k] = src;
         for (int l = 0; l < NL; l++) begin
            trial = {src.rem[l], (BIT_USED ? src.num[l][BIT_IDX] : 1'b0)};
            diff  = trial - {1'b0, src.den[l]};
            if (trial >= {1'b0, src.den[l]}) begin
               stage_in[k].rem[l] = diff[NW-1:0];
               stage_in[k].quo[l] = {src.quo[l][NS-2:0], 1'b1};
            end else begin
               stage_in[k].rem[l] = trial[NW-1:0];
               stage_in[k].quo[l] = {src.quo[l][NS-2:0], 1'b0};
            end
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            stage_ff[k] <= stage_in[k];
         end
      end
   end

   assign out_valid    = valid_ff[NS-1];
   assign out_res.side = stage_ff[NS-1].side;
   assign out_res.quo  = stage_ff[NS-1].quo;
   assign out_res.neg  = stage_ff[NS-1].neg;

endmodule

### hw/rtl/rbsi_back.sv
// ----------------------------------------------------------------------------
// rbsi_back
// Slab fold, hit decision, hit point and face match, nine register stages.
// ----------------------------------------------------------------------------
module rbsi_back (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       en,
   input  logic                       in_valid,
   input  rbsi_pkg::rbsi_div_res_type in_res,
   input  logic [30:0]                half_side,
   input  logic [15:0]                face_tol,
   output logic                       out_valid,
   output rbsi_pkg::rbsi_rsp_type     out_rsp
);

   localparam int NB = 9;
   localparam int NA = rbsi_pkg::AXES;
   localparam int NL = rbsi_pkg::LANES;
   localparam int QW = rbsi_pkg::SQ_W;

   logic [NB-1:0] valid_ff;

   rbsi_pkg::rbsi_side_type side1_ff, side2_ff, side3_ff, side4_ff, side5_ff, side6_ff;
   logic [NL-1:0][QW-1:0] qs1_ff, qs1_in;
   logic [NA-1:0][QW-1:0] ent2_ff, ent2_in, ext2_ff, ext2_in;
   logic [QW-1:0] lo3_ff, lo3_in, hi3_ff, hi3_in, ent3_ff, ext3_ff;
   logic [QW-1:0] lo4_ff, lo4_in, hi4_ff, hi4_in;
   logic          hit5_ff, hit5_in, hit6_ff, hit7_ff, hit8_ff;
   logic [30:0]   t5_ff, t5_in, t6_ff, t7_ff, t8_ff;
   logic [NA-1:0][rbsi_pkg::PROD_W-1:0] prod6_ff, prod6_in;
   logic [NA-1:0][31:0] p7_ff, p7_in, p8_ff;
   logic [NA-1:0][33:0] dp8_ff, dp8_in, dm8_ff, dm8_in;
   rbsi_pkg::rbsi_rsp_type rsp9_ff, rsp9_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (en) begin
         valid_ff <= {valid_ff[NB-2:0], in_valid};
      end
   end

   // signed slab distances
   always_comb begin
      for (int l = 0; l < NL; l++) begin
         qs1_in[l] = in_res.neg[l] ? (QW'(0) - {1'b0, in_res.quo[l]})
                                   : {1'b0, in_res.quo[l]};
      end
   end

   // entry and exit per axis, unbounded where the direction is zero
   always_comb begin
      for (int a = 0; a < NA; a++) begin
         if (side1_ff.dzero[a]) begin
            ent2_in[a] = rbsi_pkg::T_NEG_INF;
            ext2_in[a] = rbsi_pkg::T_POS_INF;
         end else if ($signed(qs1_ff[2*a]) > $signed(qs1_ff[2*a+1])) begin
            ent2_in[a] = qs1_ff[2*a+1];
            ext2_in[a] = qs1_ff[2*a];
         end else begin
            ent2_in[a] = qs1_ff[2*a];
            ext2_in[a] = qs1_ff[2*a+1];
         end
      end
   end

   // fold x and y
   assign lo3_in = ($signed(ent2_ff[1]) > $signed(ent2_ff[0])) ? ent2_ff[1] : ent2_ff[0];
   assign hi3_in = ($signed(ext2_ff[1]) < $signed(ext2_ff[0])) ? ext2_ff[1] : ext2_ff[0];

   // fold z
   assign lo4_in = ($signed(ent3_ff) > $signed(lo3_ff)) ? ent3_ff : lo3_ff;
   assign hi4_in = ($signed(ext3_ff) < $signed(hi3_ff)) ? ext3_ff : hi3_ff;

   // hit decision and saturated near distance
   assign hit5_in = !side4_ff.par_miss && !lo4_ff[QW-1] &&
                    ($signed(lo4_ff) <= $signed(hi4_ff));
   assign t5_in   = (|lo4_ff[QW-2:31]) ? rbsi_pkg::T_SAT : lo4_ff[30:0];

   // t times |dir|
   always_comb begin
      for (int a = 0; a < NA; a++) begin
         prod6_in[a] = rbsi_pkg::PROD_W'(t5_ff) * rbsi_pkg::PROD_W'(side5_ff.dmag[a]);
      end
   end

   // hit point with saturation to 32 bits
   always_comb begin
      logic signed [QW-1:0] o49, off, sum;
      for (int a = 0; a < NA; a++) begin
         o49 = $signed({{(QW-32){side6_ff.org[a][31]}}, side6_ff.org[a]});
         off = $signed({2'b00, prod6_ff[a][rbsi_pkg::PROD_W-1:16]});
         sum = side6_ff.dneg[a] ? (o49 - off) : (o49 + off);
         if (sum > $signed(QW'(32'h7FFF_FFFF))) begin
            p7_in[a] = 32'h7FFF_FFFF;
         end else if (sum < -$signed(QW'(33'h0_8000_0000))) begin
            p7_in[a] = 32'h8000_0000;
         end else begin
            p7_in[a] = sum[31:0];
         end
      end
   end

   // distance to the plus and minus planes
   always_comb begin
      logic signed [33:0] p34, h34;
      for (int a = 0; a < NA; a++) begin
         p34       = $signed({{2{p7_ff[a][31]}}, p7_ff[a]});
         h34       = $signed({3'b000, half_side});
         dp8_in[a] = p34 - h34;
         dm8_in[a] = p34 + h34;
      end
   end

   // face match, later checks override, minus faces last; on a miss all fields are zero and face is FACE_NONE
   always_comb begin
      logic [33:0] ap, am, tol34;
      logic [2:0]  face;
      tol34 = {18'd0, face_tol};
      face  = rbsi_pkg::FACE_NONE;
      for (int a = 0; a < NA; a++) begin
         ap = dp8_ff[a][33] ? (34'd0 - dp8_ff[a]) : dp8_ff[a];
         if (ap <= tol34) begin
            face = rbsi_pkg::FACE_PX + 3'(a);
         end
      end
      for (int a = 0; a < NA; a++) begin
         am = dm8_ff[a][33] ? (34'd0 - dm8_ff[a]) : dm8_ff[a];
         if (am <= tol34) begin
            face = rbsi_pkg::FACE_MX + 3'(a);
         end
      end
      if (hit8_ff) begin
         rsp9_in.hit     = 1'b1;
         rsp9_in.t_hit   = t8_ff;
         rsp9_in.point_x = p8_ff[0];
         rsp9_in.point_y = p8_ff[1];
         rsp9_in.point_z = p8_ff[2];
         rsp9_in.face    = face;
      end else begin
         rsp9_in         = '0;
         rsp9_in.face    = rbsi_pkg::FACE_NONE;
      end
   end

   // stage registers
   always_ff @(posedge clock) begin
      if (en) begin
         side1_ff <= in_res.side;
         qs1_ff   <= qs1_in;
         side2_ff <= side1_ff;
         ent2_ff  <= ent2_in;
         ext2_ff  <= ext2_in;
         side3_ff <= side2_ff;
         lo3_ff   <= lo3_in;
         hi3_ff   <= hi3_in;
         ent3_ff  <= ent2_ff[2];
         ext3_ff  <= ext2_ff[2];
         side4_ff <= side3_ff;
         lo4_ff   <= lo4_in;
         hi4_ff   <= hi4_in;
         side5_ff <= side4_ff;
         hit5_ff  <= hit5_in;
         t5_ff    <= t5_in;
         side6_ff <= side5_ff;
         hit6_ff  <= hit5_ff;
         t6_ff    <= t5_ff;
         prod6_ff <= prod6_in;
         hit7_ff  <= hit6_ff;
         t7_ff    <= t6_ff;
         p7_ff    <= p7_in;
         hit8_ff  <= hit7_ff;
         t8_ff    <= t7_ff;
         p8_ff    <= p7_ff;
         dp8_ff   <= dp8_in;
         dm8_ff   <= dm8_in;
         rsp9_ff  <= rsp9_in;
      end
   end

   assign out_valid = valid_ff[NB-1];
   assign out_rsp   = rsp9_ff;

endmodule

### hw/rtl/rbsi_out_buf.sv
// ----------------------------------------------------------------------------
// rbsi_out_buf
// Two-entry result buffer between the pipeline and the result channel.
// ----------------------------------------------------------------------------
module rbsi_out_buf (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   push,
   input  rbsi_pkg::rbsi_rsp_type push_data,
   output logic                   full,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output rbsi_pkg::rbsi_rsp_type rsp_data
);

   rbsi_pkg::rbsi_rsp_type buf_ff [2];
   logic       wr_ptr_ff, rd_ptr_ff;
   logic [1:0] count_ff;
   logic       pop;

   assign pop       = rsp_valid && rsp_ready;
   assign rsp_valid = (count_ff != 2'd0);
   assign full      = (count_ff == 2'd2);
   assign rsp_data  = buf_ff[rd_ptr_ff];

   // pointers and fill count
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         if (push) begin
            wr_ptr_ff <= ~wr_ptr_ff;
         end
         if (pop) begin
            rd_ptr_ff <= ~rd_ptr_ff;
         end
         if (push && !pop) begin
            count_ff <= count_ff + 2'd1;
         end else if (pop && !push) begin
            count_ff <= count_ff - 2'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         buf_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

### hw/rtl/ray_box_slab_intersect.sv
// ----------------------------------------------------------------------------
// ray_box_slab_intersect
// Ray versus origin-centred cube slab test, one ray per cycle.
// A req beat passes 1 input stage, 48 divider stages of one quotient bit
//   each, 9 fold/point/face stages and the result buffer on its way to rsp.
// Throughput: one ray per cycle; the pipeline holds only while the
//   two-entry result buffer is full.
// Reset: synchronous, clears valid bits and buffer; registers return to
//   half_side 0.5 and face_tolerance 16.
// ----------------------------------------------------------------------------
module ray_box_slab_intersect (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_ready,
   input  rbsi_pkg::rbsi_req_type            req_data,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output rbsi_pkg::rbsi_rsp_type            rsp_data,
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [rbsi_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [31:0]                       csr_wdata
);

   logic [30:0] half_side_ff;
   logic [15:0] face_tol_ff;
   logic        en, full;
   logic        front_valid, div_valid, back_valid;
   rbsi_pkg::rbsi_side_type    front_side;
   rbsi_pkg::rbsi_div_op_type  front_op;
   rbsi_pkg::rbsi_div_res_type div_res;
   rbsi_pkg::rbsi_rsp_type     back_rsp;

   // configuration registers
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         half_side_ff <= rbsi_pkg::HALF_SIDE_RST;
         face_tol_ff  <= rbsi_pkg::FACE_TOL_RST;
      end else if (csr_valid) begin
         unique case (csr_index)
            rbsi_pkg::CSR_HALF_SIDE: half_side_ff <= csr_wdata[30:0];
            rbsi_pkg::CSR_FACE_TOL:  face_tol_ff  <= csr_wdata[15:0];
            default: ;
         endcase
      end
   end

   // whole pipeline advances while the result buffer has room
   assign en        = !full;
   assign req_ready = en;

   rbsi_front u_front (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (req_valid),
      .in_req    (req_data),
      .half_side (half_side_ff),
      .out_valid (front_valid),
      .out_side  (front_side),
      .out_op    (front_op)
   );

   rbsi_div_pipe u_div (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (front_valid),
      .in_side   (front_side),
      .in_op     (front_op),
      .out_valid (div_valid),
      .out_res   (div_res)
   );

   rbsi_back u_back (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (div_valid),
      .in_res    (div_res),
      .half_side (half_side_ff),
      .face_tol  (face_tol_ff),
      .out_valid (back_valid),
      .out_rsp   (back_rsp)
   );

   rbsi_out_buf u_out_buf (
      .clock     (clock),
      .reset     (reset),
      .push      (back_valid && en),
      .push_data (back_rsp),
      .full      (full),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

endmodule

### test/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the ray versus cube slab test. Rays are pushed
// through the req channel with random gaps, results are drawn off with
// random stalls and compared field by field against an in-bench predictor
// of the slab test, across several cube sizes and face tolerances.
// ----------------------------------------------------------------------------
module tb;

   localparam int  PIPE_DRAIN = 72;
   localparam int  CYCLE_LIMIT = 600000;
   localparam longint H_MAX = 64'h7FFF_FFFF;

   logic                           clock = 1'b0;
   logic                           reset = 1'b1;
   logic                           req_valid = 1'b0;
   logic                           req_ready;
   rbsi_pkg::rbsi_req_type         req_data = '0;
   logic                           rsp_valid;
   logic                           rsp_ready = 1'b0;
   rbsi_pkg::rbsi_rsp_type         rsp_data;
   logic                           csr_valid = 1'b0;
   logic                           csr_ready;
   logic [rbsi_pkg::CSR_IDX_W-1:0] csr_index = '0;
   logic [31:0]                    csr_wdata = '0;

   // bench copy of the registers
   logic [30:0] half_side_q = rbsi_pkg::HALF_SIDE_RST;
   logic [15:0] face_tol_q  = rbsi_pkg::FACE_TOL_RST;

   rbsi_pkg::rbsi_rsp_type expected_rsp_q[$];
   int  n_errors   = 0;
   int  n_rays     = 0;
   int  n_hits     = 0;
   int  n_results  = 0;
   int  n_settings = 1;
   int  cycles     = 0;
   int  rsp_hold   = 0;
   bit  req_busy   = 1'b0;
   bit  rsp_busy   = 1'b0;

   ray_box_slab_intersect u_top (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always #4 clock = ~clock;

   // watchdog
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("CHECKS FAILED");
         $finish;
      end
   end

   // slab test predictor
   function automatic rbsi_pkg::rbsi_rsp_type slab_hit(input rbsi_pkg::rbsi_req_type r);
      longint org[3];
      longint dir[3];
      longint pt[3];
      longint h, tol, near_t, far_t, t_in, t_out, swp, sum, dmag;
      longint unsigned t, off;
      bit in_box;
      int i;
      logic [2:0] f;
      rbsi_pkg::rbsi_rsp_type res;
      org[0] = r.origin_x; org[1] = r.origin_y; org[2] = r.origin_z;
      dir[0] = r.dir_x;    dir[1] = r.dir_y;    dir[2] = r.dir_z;
      h      = longint'({33'd0, half_side_q});
      tol    = longint'({48'd0, face_tol_q});
      near_t = 64'sh8000_0000_0000_0000;
      far_t  = 64'sh7FFF_FFFF_FFFF_FFFF;
      in_box = 1'b1;
      res    = '0;
      res.face = rbsi_pkg::FACE_NONE;
      // fold each slab into the near and far bounds
      for (i = 0; i < 3 && in_box; i++) begin
         if (dir[i] == 0) begin
            in_box = !(org[i] < -h || org[i] > h);
         end else begin
            t_in  = ((-h - org[i]) * 65536) / dir[i];
            t_out = ((h - org[i]) * 65536) / dir[i];
            if (t_in > t_out) begin
               swp = t_in; t_in = t_out; t_out = swp;
            end
            if (t_in > near_t) near_t = t_in;
            if (t_out < far_t) far_t = t_out;
         end
      end
      if (in_box && (near_t > far_t || near_t < 0)) in_box = 1'b0;
      if (!in_box) return res;
      t = (near_t > H_MAX) ? longint'(H_MAX) : near_t;
      // hit point, magnitude truncated then saturated
      for (i = 0; i < 3; i++) begin
         dmag = (dir[i] < 0) ? -dir[i] : dir[i];
         off  = (t * longint'(dmag)) >> 16;
         sum  = (dir[i] < 0) ? org[i] - longint'(off) : org[i] + longint'(off);
         if (sum > H_MAX) sum = H_MAX;
         if (sum < -H_MAX - 1) sum = -H_MAX - 1;
         pt[i] = sum;
      end
      // later face matches win, minus faces last
      f = rbsi_pkg::FACE_NONE;
      for (i = 0; i < 3; i++)
         if ((pt[i] - h <= tol) && (h - pt[i] <= tol)) f = rbsi_pkg::FACE_PX + 3'(i);
      for (i = 0; i < 3; i++)
         if ((pt[i] + h <= tol) && (-h - pt[i] <= tol)) f = rbsi_pkg::FACE_MX + 3'(i);
      res.hit     = 1'b1;
      res.t_hit   = t[30:0];
      res.point_x = pt[0][31:0];
      res.point_y = pt[1][31:0];
      res.point_z = pt[2][31:0];
      res.face    = f;
      return res;
   endfunction

   // result side stall
   always @(negedge clock) begin
      if (rsp_hold > 0) begin
         rsp_ready <= 1'b0;
         rsp_hold  <= rsp_hold - 1;
      end else begin
         rsp_ready <= 1'b1;
      end
   end

   // result checker
   always @(posedge clock) begin
      rbsi_pkg::rbsi_rsp_type exp_r;
      if (!reset && rsp_valid && rsp_ready) begin
         n_results++;
         rsp_hold <= rsp_busy ? $urandom_range(0, 15) : 0;
         if (expected_rsp_q.size() == 0) begin
            $error("result beat with nothing expected");
            n_errors++;
         end else begin
            exp_r = expected_rsp_q.pop_front();
            if (exp_r.hit) n_hits++;
            if (rsp_data.hit !== exp_r.hit) begin
               $error("hit: expected %0d actual %0d", exp_r.hit, rsp_data.hit);
               n_errors++;
            end
            if (rsp_data.t_hit !== exp_r.t_hit) begin
               $error("t_hit: expected %h actual %h", exp_r.t_hit, rsp_data.t_hit);
               n_errors++;
            end
            if (rsp_data.point_x !== exp_r.point_x) begin
               $error("point_x: expected %h actual %h", exp_r.point_x, rsp_data.point_x);
               n_errors++;
            end
            if (rsp_data.point_y !== exp_r.point_y) begin
               $error("point_y: expected %h actual %h", exp_r.point_y, rsp_data.point_y);
               n_errors++;
            end
            if (rsp_data.point_z !== exp_r.point_z) begin
               $error("point_z: expected %h actual %h", exp_r.point_z, rsp_data.point_z);
               n_errors++;
            end
            if (rsp_data.face !== exp_r.face) begin
               $error("face: expected %0d actual %0d", exp_r.face, rsp_data.face);
               n_errors++;
            end
         end
      end
   end

   // one ray beat, returns at the accepting edge
   task automatic send_ray(input rbsi_pkg::rbsi_req_type r);
      int gap;
      gap = req_busy ? $urandom_range(0, 15) : 0;
      @(negedge clock);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= r;
      do @(posedge clock); while (!req_ready);
      expected_rsp_q.push_back(slab_hit(r));
      n_rays++;
   endtask

   task automatic drain_pipe();
      @(negedge clock);
      req_valid <= 1'b0;
      while (expected_rsp_q.size() != 0) @(posedge clock);
      repeat (PIPE_DRAIN) @(posedge clock);
   endtask

   // register write, pipe drained first
   task automatic write_reg(input logic [rbsi_pkg::CSR_IDX_W-1:0] idx,
                            input logic [31:0] val);
      drain_pipe();
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      do @(posedge clock); while (!csr_ready);
      if (idx == rbsi_pkg::CSR_HALF_SIDE) half_side_q = val[30:0];
      else if (idx == rbsi_pkg::CSR_FACE_TOL) face_tol_q = val[15:0];
      @(negedge clock);
      csr_valid <= 1'b0;
      n_settings++;
   endtask

   function automatic rbsi_pkg::rbsi_req_type make_ray(input longint ox, oy, oz,
                                                       dx, dy, dz);
      rbsi_pkg::rbsi_req_type r;
      r.origin_x = ox[31:0]; r.origin_y = oy[31:0]; r.origin_z = oz[31:0];
      r.dir_x    = dx[31:0]; r.dir_y    = dy[31:0]; r.dir_z    = dz[31:0];
      return r;
   endfunction

   function automatic longint clamp32(input longint v);
      if (v > H_MAX) return H_MAX;
      if (v < -H_MAX - 1) return -H_MAX - 1;
      return v;
   endfunction

   // uniform in [-lim, lim]
   function automatic longint rand_span(input longint lim);
      longint unsigned r;
      r = {$urandom, $urandom};
      return longint'(r % longint'(2 * lim + 1)) - lim;
   endfunction

   // random ray: mostly aimed at the cube, some axis-parallel, some noise
   function automatic rbsi_pkg::rbsi_req_type random_ray();
      longint h, o[3], d[3];
      int i, kind;
      rbsi_pkg::rbsi_req_type r;
      h    = longint'({33'd0, half_side_q});
      kind = $urandom_range(0, 9);
      for (i = 0; i < 3; i++) begin
         o[i] = clamp32(rand_span(3 * h + 4));
         d[i] = clamp32(rand_span(h + 1) - o[i]);
         if ($urandom_range(0, 3) == 0) d[i] = d[i] >>> $urandom_range(0, 31);
         if (kind >= 6 && $urandom_range(0, 2) == 0) d[i] = 0;
      end
      if (kind == 9) begin
         r = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
         return r;
      end
      return make_ray(o[0], o[1], o[2], d[0], d[1], d[2]);
   endfunction

   // each axis and direction, parallel rays, degenerate and extreme rays
   task automatic test_directed_defaults();
      int ax;
      longint p[3], q[3];
      for (ax = 0; ax < 3; ax++) begin
         p = '{0, 0, 0}; q = '{0, 0, 0};
         p[ax] = -32'sh2_0000; q[ax] = 32'sh1_0000;
         send_ray(make_ray(p[0], p[1], p[2], q[0], q[1], q[2]));
         p[ax] = 32'sh2_0000; q[ax] = -32'sh1_0000;
         send_ray(make_ray(p[0], p[1], p[2], q[0], q[1], q[2]));
      end
      send_ray(make_ray(0, 32'sh1_0000, 0, 32'sh1_0000, 0, 0));    // parallel, outside
      send_ray(make_ray(-32'sh2_0000, 32'sh4000, 0, 32'sh1_0000, 0, 0));
      send_ray(make_ray(0, 0, 0, 0, 0, 0));                       // no direction at all
      send_ray(make_ray(0, 0, 0, 32'sh1_0000, 0, 0));             // starts within the cube
      send_ray(make_ray(32'sh2_0000, 0, 0, 32'sh1_0000, 0, 0));   // cube behind
      send_ray(make_ray(-32'sh2_0000, -32'sh2_0000, -32'sh2_0000,
                        32'sh1_0000, 32'sh1_0000, 32'sh1_0000)); // corner
      send_ray(make_ray(-H_MAX - 1, 0, 0, 1, 0, 0));              // saturated distance
      send_ray(make_ray(-H_MAX - 1, -H_MAX - 1, -H_MAX - 1, H_MAX, H_MAX, H_MAX));
      send_ray(make_ray(H_MAX, H_MAX, H_MAX, -H_MAX - 1, -H_MAX - 1, -H_MAX - 1));
      send_ray(make_ray(H_MAX, 0, 0, -1, 0, 0));
      send_ray(make_ray(-H_MAX - 1, 32'sh7FFF, -32'sh8000, H_MAX, 0, 0));
      send_ray(make_ray(-32'sh3_0000, 0, 0, 32'sh1_0000, 32'sh1_0000, 0)); // misses
   endtask

   // unused indexes, masked upper bits and degenerate sizes
   task automatic test_register_edges();
      write_reg(2'd2, 32'h0000_0001);
      write_reg(2'd3, 32'hFFFF_FFFF);
      send_ray(make_ray(-32'sh2_0000, 0, 0, 32'sh1_0000, 0, 0));
      write_reg(rbsi_pkg::CSR_HALF_SIDE, 32'h0000_0000);
      write_reg(rbsi_pkg::CSR_FACE_TOL, 32'hFFFF_0000);
      send_ray(make_ray(-32'sh2_0000, 0, 0, 32'sh1_0000, 0, 0));
      send_ray(make_ray(0, 0, 0, 0, 0, 0));
      write_reg(rbsi_pkg::CSR_HALF_SIDE, 32'hFFFF_FFFF);
      send_ray(make_ray(-H_MAX - 1, 0, 0, 1, 0, 0));
   endtask

   // random rays under a run of register settings
   task automatic test_random_sweep();
      logic [31:0] halves[8];
      logic [31:0] tols[8];
      int s, k;
      halves = '{32'h0000_8000, 32'h0000_0001, 32'h7FFF_FFFF, 32'h0001_0000,
                 32'h8000_0000, 32'h0100_0000, 32'h0000_0100, $urandom};
      tols   = '{32'd0, 32'h0000_FFFF, 32'd16, 32'd1, 32'hFFFF_8000, 32'd256,
                 32'd4096, $urandom};
      for (s = 0; s < 8; s++) begin
         write_reg(rbsi_pkg::CSR_HALF_SIDE, halves[s]);
         write_reg(rbsi_pkg::CSR_FACE_TOL, tols[s]);
         for (k = 0; k < 130; k++) begin
            // alternate busy and back-to-back stretches on both sides
            req_busy = ((k / 40) % 3) != 1;
            rsp_busy = ((k / 25) % 3) != 2;
            send_ray(random_ray());
         end
      end
   endtask

   initial begin
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      test_directed_defaults();
      req_busy = 1'b1;
      rsp_busy = 1'b1;
      test_directed_defaults();
      test_register_edges();
      test_random_sweep();
      drain_pipe();
      $display("sent %0d rays, %0d results back, %0d hits", n_rays, n_results, n_hits);
      $display("%0d register writes over cube sizes from zero to maximum", n_settings - 1);
      if (n_errors == 0 && expected_rsp_q.size() == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule
